FILE: sv/set_assoc_cache_tag_lookup_unit_defines.svh
// Assertion shorthands shared by the cache tag lookup RTL.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_UNIT_DEFINES_SVH

// Condition must hold at every enabled edge.
`define SACTL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SACTL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SACTL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/sactl_pkg.sv
`default_nettype none

package sactl_pkg;

   // Fixed field widths of the request and response payloads
   localparam int ADDR_W      = 48;
   localparam int TAG_OUT_W   = 48;
   localparam int SET_OUT_W   = 6;
   localparam int OFF_OUT_W   = 16;
   localparam int WAY_OUT_W   = 2;
   localparam int CNT_W       = 32;
   localparam int RAW_SETS    = 2 ** SET_OUT_W;

   // Field width clamps
   localparam logic [4:0] OFF_BITS_MAX = 5'd16;
   localparam logic [2:0] IDX_BITS_MAX = 3'd6;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFF_WIDTH   = 2'd0,
      CSR_IDX_WIDTH   = 2'd1,
      CSR_POLICY      = 2'd2,
      CSR_WAYS_IN_USE = 2'd3
   } csr_index_type;

   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   localparam logic [4:0] OFF_WIDTH_RST   = 5'd4;
   localparam logic [2:0] IDX_WIDTH_RST   = 3'd6;
   localparam logic       POLICY_RST      = POLICY_LRU;
   localparam logic [2:0] WAYS_IN_USE_RST = 3'd4;

   // Parameter defaults
   localparam int SET_COUNT_DEF  = 64;
   localparam int WAYS_DEF       = 4;
   localparam int ADDR_BITS_DEF  = 48;
   localparam int STAMP_BITS_DEF = 32;

endpackage

`default_nettype wire

FILE: sv/sactl_req_if.sv
`default_nettype none

interface sactl_req_if;
   import sactl_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] address;

   modport source (output valid, output address, input ready);
   modport sink (input valid, input address, output ready);
endinterface

`default_nettype wire

FILE: sv/sactl_rsp_if.sv
`default_nettype none

interface sactl_rsp_if;
   import sactl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 hit;
   logic [WAY_OUT_W-1:0] way;
   logic                 evicted;
   logic [TAG_OUT_W-1:0] evicted_tag;
   logic [TAG_OUT_W-1:0] tag;
   logic [SET_OUT_W-1:0] set_index;
   logic [OFF_OUT_W-1:0] offset;
   logic [CNT_W-1:0]     access_number;
   logic [CNT_W-1:0]     hit_total;
   logic [CNT_W-1:0]     miss_total;

   modport source (
      output valid, output hit, output way, output evicted, output evicted_tag,
      output tag, output set_index, output offset, output access_number,
      output hit_total, output miss_total, input ready
   );
   modport sink (
      input valid, input hit, input way, input evicted, input evicted_tag,
      input tag, input set_index, input offset, input access_number,
      input hit_total, input miss_total, output ready
   );
endinterface

`default_nettype wire

FILE: sv/set_assoc_cache_tag_lookup_unit.sv
`default_nettype none

// Set-associative cache tag lookup with LRU or FIFO replacement. Each request
// carries one address, which is split into byte offset, set index and tag by
// the offset width and index width registers (clamped to 16 and 6). The ways
// in use of the selected set are read one at a time from a single tag/stamp
// RAM and checked by one shared tag and stamp comparator. A hit under LRU
// restamps the line; a miss fills the first invalid way, else the way with the
// oldest stamp, and reports the evicted tag. A request passes through an accept
// state, a read state and a compare state per way on the single RAM read port,
// and a write-back state; the search ends at the hit way, or after all ways in
// use on a miss. The response sits in an output register, so the next request
// is accepted while it waits; the write-back state of that next request holds
// for as long as the earlier response is not taken. Line valid bits are
// flip-flops cleared by reset, so no clearing pass is needed after reset.
// Configuration writes take effect at once and must only be issued while no
// request is in flight.
module set_assoc_cache_tag_lookup_unit #(
   parameter int SET_COUNT  = sactl_pkg::SET_COUNT_DEF,
   parameter int WAYS       = sactl_pkg::WAYS_DEF,
   parameter int ADDR_BITS  = sactl_pkg::ADDR_BITS_DEF,
   parameter int STAMP_BITS = sactl_pkg::STAMP_BITS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   sactl_req_if.sink                             req_bus,
   sactl_rsp_if.source                           rsp_bus,
   input  wire logic                             csr_wr_en,
   input  wire logic [sactl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [sactl_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   import sactl_pkg::*;

`include "set_assoc_cache_tag_lookup_unit_defines.svh"

   localparam int LINES   = SET_COUNT * WAYS;
   localparam int LINE_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int TAG_W   = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int ENTRY_W = TAG_W + STAMP_BITS;

   localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}} :
      ADDR_W'((64'(1) << ADDR_BITS) - 64'(1));
   localparam logic [STAMP_BITS-1:0] STAMP_MAX = {STAMP_BITS{1'b1}};
   localparam logic [CNT_W-1:0]      CNT_MAX   = {CNT_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_WRITE
   } state_type;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [4:0] off_width_ff;
   logic [2:0] idx_width_ff;
   logic       policy_ff;
   logic [2:0] ways_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_width_ff   <= OFF_WIDTH_RST;
         idx_width_ff   <= IDX_WIDTH_RST;
         policy_ff      <= POLICY_RST;
         ways_in_use_ff <= WAYS_IN_USE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OFF_WIDTH:   off_width_ff   <= csr_wr_data;
            CSR_IDX_WIDTH:   idx_width_ff   <= csr_wr_data[2:0];
            CSR_POLICY:      policy_ff      <= csr_wr_data[0];
            CSR_WAYS_IN_USE: ways_in_use_ff <= csr_wr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Address split (evaluated on the accept cycle)
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0]    addr_masked;
   logic [4:0]           off_sh;
   logic [2:0]           idx_sh;
   logic [5:0]           tag_sh;
   logic [OFF_OUT_W-1:0] off_mask;
   logic [SET_OUT_W-1:0] idx_mask;
   logic [ADDR_W-1:0]    addr_above_off;
   logic [SET_OUT_W-1:0] raw_idx;
   logic [SET_OUT_W-1:0] set_map [RAW_SETS];
   logic [SET_OUT_W-1:0] dec_set;
   logic [OFF_OUT_W-1:0] dec_off;
   logic [TAG_W-1:0]     dec_tag;
   logic [LINE_W-1:0]    dec_base;
   logic [3:0]           last_calc;

   // Fold a raw index into the sets present
   for (genvar g = 0; g < RAW_SETS; g++) begin : g_set_map
      assign set_map[g] = SET_OUT_W'(g % SET_COUNT);
   end

   always_comb begin
      addr_masked    = req_bus.address & ADDR_MASK;
      off_sh         = (off_width_ff > OFF_BITS_MAX) ? OFF_BITS_MAX : off_width_ff;
      idx_sh         = (idx_width_ff > IDX_BITS_MAX) ? IDX_BITS_MAX : idx_width_ff;
      tag_sh         = 6'(off_sh) + 6'(idx_sh);
      off_mask       = OFF_OUT_W'((17'(1) << off_sh) - 17'(1));
      idx_mask       = SET_OUT_W'((7'(1) << idx_sh) - 7'(1));
      addr_above_off = addr_masked >> off_sh;
      raw_idx        = addr_above_off[SET_OUT_W-1:0] & idx_mask;
      dec_set        = set_map[raw_idx];
      dec_off        = addr_masked[OFF_OUT_W-1:0] & off_mask;
      dec_tag        = TAG_W'(addr_masked >> tag_sh);
      dec_base       = LINE_W'(dec_set) * LINE_W'(WAYS);
      if (ways_in_use_ff == 3'd0) begin
         last_calc = 4'd0;
      end else if (32'(ways_in_use_ff) > WAYS) begin
         last_calc = 4'(WAYS - 1);
      end else begin
         last_calc = 4'(ways_in_use_ff) - 4'd1;
      end
   end

   // ------------------------------------------------------------------
   // Tag/stamp RAM and line valid bits
   // ------------------------------------------------------------------
   logic                  ram_rd_en;
   logic                  ram_wr_en;
   logic [LINE_W-1:0]     rd_line;
   logic [LINE_W-1:0]     wr_line;
   logic [ENTRY_W-1:0]    ram_rd_data;
   logic [TAG_W-1:0]      tag_ff;
   logic [STAMP_BITS-1:0] time_now_ff;
   logic                  line_valid_ff [LINES];
   logic                  line_valid_in [LINES];

   sactl_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_line),
      .wr_data ({tag_ff, time_now_ff}),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_line),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   state_type             state_ff,     state_in;
   logic [WAY_W-1:0]      way_ff,       way_in;
   logic [WAY_W-1:0]      last_way_ff,  last_way_in;
   logic [LINE_W-1:0]     base_ff,      base_in;
   logic [TAG_W-1:0]                    tag_in;
   logic [SET_OUT_W-1:0]  set_ff,       set_in;
   logic [OFF_OUT_W-1:0]  off_ff,       off_in;
   logic                  hit_ff,       hit_in;
   logic [WAY_W-1:0]      hit_way_ff,   hit_way_in;
   logic                  found_inv_ff, found_inv_in;
   logic [WAY_W-1:0]      inv_way_ff,   inv_way_in;
   logic [WAY_W-1:0]      min_way_ff,   min_way_in;
   logic [STAMP_BITS-1:0] min_stamp_ff, min_stamp_in;
   logic [TAG_W-1:0]      min_tag_ff,   min_tag_in;
   logic [STAMP_BITS-1:0]               time_now_in;
   logic [CNT_W-1:0]      access_ff,    access_in;
   logic [CNT_W-1:0]      hitc_ff,      hitc_in;
   logic [CNT_W-1:0]      missc_ff,     missc_in;

   // Response register
   logic                  rsp_valid_ff,       rsp_valid_in;
   logic                  rsp_hit_ff,         rsp_hit_in;
   logic [WAY_OUT_W-1:0]  rsp_way_ff,         rsp_way_in;
   logic                  rsp_evicted_ff,     rsp_evicted_in;
   logic [TAG_OUT_W-1:0]  rsp_evicted_tag_ff, rsp_evicted_tag_in;
   logic [TAG_OUT_W-1:0]  rsp_tag_ff,         rsp_tag_in;
   logic [SET_OUT_W-1:0]  rsp_set_ff,         rsp_set_in;
   logic [OFF_OUT_W-1:0]  rsp_off_ff,         rsp_off_in;
   logic [CNT_W-1:0]      rsp_access_ff,      rsp_access_in;
   logic [CNT_W-1:0]      rsp_hitc_ff,        rsp_hitc_in;
   logic [CNT_W-1:0]      rsp_missc_ff,       rsp_missc_in;

   logic [TAG_W-1:0]      rd_tag;
   logic [STAMP_BITS-1:0] rd_stamp;
   logic                  rd_valid;
   logic                  out_free;
   logic                  evict;
   logic [WAY_W-1:0]      fill_way;
   logic [WAY_W-1:0]      res_way;
   logic [WAY_W+1:0]      way_ext;

   assign rd_tag   = ram_rd_data[ENTRY_W-1:STAMP_BITS];
   assign rd_stamp = ram_rd_data[STAMP_BITS-1:0];
   assign rd_line  = base_ff + LINE_W'(way_ff);
   assign rd_valid = line_valid_ff[rd_line];
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Pick the line to write: the hit line, else first invalid, else oldest
   assign evict    = !hit_ff && !found_inv_ff;
   assign fill_way = hit_ff ? hit_way_ff : (found_inv_ff ? inv_way_ff : min_way_ff);
   assign wr_line  = base_ff + LINE_W'(fill_way);
   assign res_way  = hit_ff ? '0 : fill_way;
   assign way_ext  = {2'b00, res_way};

   always_comb begin
      state_in     = state_ff;
      way_in       = way_ff;
      last_way_in  = last_way_ff;
      base_in      = base_ff;
      tag_in       = tag_ff;
      set_in       = set_ff;
      off_in       = off_ff;
      hit_in       = hit_ff;
      hit_way_in   = hit_way_ff;
      found_inv_in = found_inv_ff;
      inv_way_in   = inv_way_ff;
      min_way_in   = min_way_ff;
      min_stamp_in = min_stamp_ff;
      min_tag_in   = min_tag_ff;
      time_now_in  = time_now_ff;
      access_in    = access_ff;
      hitc_in      = hitc_ff;
      missc_in     = missc_ff;
      line_valid_in = line_valid_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;

      // Drop the response once taken; a new load below overrides
      rsp_valid_in       = rsp_valid_ff && !rsp_bus.ready;
      rsp_hit_in         = rsp_hit_ff;
      rsp_way_in         = rsp_way_ff;
      rsp_evicted_in     = rsp_evicted_ff;
      rsp_evicted_tag_in = rsp_evicted_tag_ff;
      rsp_tag_in         = rsp_tag_ff;
      rsp_set_in         = rsp_set_ff;
      rsp_off_in         = rsp_off_ff;
      rsp_access_in      = rsp_access_ff;
      rsp_hitc_in        = rsp_hitc_ff;
      rsp_missc_in       = rsp_missc_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               tag_in       = dec_tag;
               set_in       = dec_set;
               off_in       = dec_off;
               base_in      = dec_base;
               last_way_in  = WAY_W'(last_calc);
               way_in       = '0;
               hit_in       = 1'b0;
               found_inv_in = 1'b0;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            ram_rd_en = 1'b1;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            if (rd_valid && (rd_tag == tag_ff)) begin
               hit_in     = 1'b1;
               hit_way_in = way_ff;
               state_in   = ST_WRITE;
            end else begin
               if (!rd_valid && !found_inv_ff) begin
                  found_inv_in = 1'b1;
                  inv_way_in   = way_ff;
               end
               // Strict compare keeps the lowest way on equal stamps
               if ((way_ff == '0) || (rd_stamp < min_stamp_ff)) begin
                  min_way_in   = way_ff;
                  min_stamp_in = rd_stamp;
                  min_tag_in   = rd_tag;
               end
               if (way_ff == last_way_ff) begin
                  state_in = ST_WRITE;
               end else begin
                  way_in   = way_ff + WAY_W'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_WRITE: begin
            if (out_free) begin
               ram_wr_en = !hit_ff || (policy_ff == POLICY_LRU);
               if (ram_wr_en) begin
                  line_valid_in[wr_line] = 1'b1;
                  if (time_now_ff != STAMP_MAX) begin
                     time_now_in = time_now_ff + STAMP_BITS'(1);
                  end
               end
               if (access_ff != CNT_MAX) begin
                  access_in = access_ff + CNT_W'(1);
               end
               if (hit_ff) begin
                  if (hitc_ff != CNT_MAX) begin
                     hitc_in = hitc_ff + CNT_W'(1);
                  end
               end else if (missc_ff != CNT_MAX) begin
                  missc_in = missc_ff + CNT_W'(1);
               end
               rsp_valid_in       = 1'b1;
               rsp_hit_in         = hit_ff;
               rsp_way_in         = way_ext[WAY_OUT_W-1:0];
               rsp_evicted_in     = evict;
               rsp_evicted_tag_in = evict ? TAG_OUT_W'(min_tag_ff) : '0;
               rsp_tag_in         = TAG_OUT_W'(tag_ff);
               rsp_set_in         = set_ff;
               rsp_off_in         = off_ff;
               rsp_access_in      = access_in;
               rsp_hitc_in        = hitc_in;
               rsp_missc_in       = missc_in;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         time_now_ff  <= '0;
         access_ff    <= '0;
         hitc_ff      <= '0;
         missc_ff     <= '0;
         for (int i = 0; i < LINES; i++) begin
            line_valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         time_now_ff   <= time_now_in;
         access_ff     <= access_in;
         hitc_ff       <= hitc_in;
         missc_ff      <= missc_in;
         line_valid_ff <= line_valid_in;
      end
      // Payload: no reset needed
      way_ff             <= way_in;
      last_way_ff        <= last_way_in;
      base_ff            <= base_in;
      tag_ff             <= tag_in;
      set_ff             <= set_in;
      off_ff             <= off_in;
      hit_ff             <= hit_in;
      hit_way_ff         <= hit_way_in;
      found_inv_ff       <= found_inv_in;
      inv_way_ff         <= inv_way_in;
      min_way_ff         <= min_way_in;
      min_stamp_ff       <= min_stamp_in;
      min_tag_ff         <= min_tag_in;
      rsp_hit_ff         <= rsp_hit_in;
      rsp_way_ff         <= rsp_way_in;
      rsp_evicted_ff     <= rsp_evicted_in;
      rsp_evicted_tag_ff <= rsp_evicted_tag_in;
      rsp_tag_ff         <= rsp_tag_in;
      rsp_set_ff         <= rsp_set_in;
      rsp_off_ff         <= rsp_off_in;
      rsp_access_ff      <= rsp_access_in;
      rsp_hitc_ff        <= rsp_hitc_in;
      rsp_missc_ff       <= rsp_missc_in;
   end

   // ------------------------------------------------------------------
   // Ports
   // ------------------------------------------------------------------
   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.hit           = rsp_hit_ff;
   assign rsp_bus.way           = rsp_way_ff;
   assign rsp_bus.evicted       = rsp_evicted_ff;
   assign rsp_bus.evicted_tag   = rsp_evicted_tag_ff;
   assign rsp_bus.tag           = rsp_tag_ff;
   assign rsp_bus.set_index     = rsp_set_ff;
   assign rsp_bus.offset        = rsp_off_ff;
   assign rsp_bus.access_number = rsp_access_ff;
   assign rsp_bus.hit_total     = rsp_hitc_ff;
   assign rsp_bus.miss_total    = rsp_missc_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `SACTL_ASSERT_IMPL(a_hit_no_evict, clock, reset, rsp_valid_ff && rsp_hit_ff,
      !rsp_evicted_ff && (rsp_way_ff == '0), "hit response carries an eviction or a nonzero way")
   `SACTL_ASSERT_IMPL(a_fifo_hit_no_write, clock, reset, ram_wr_en,
      !hit_ff || (policy_ff == POLICY_LRU), "line rewritten on a FIFO hit")
   `SACTL_ASSERT_NEXT(a_time_monotonic, clock, reset, !reset,
      time_now_ff >= $past(time_now_ff), "time counter moved backward")
   `SACTL_ASSERT_IMPL(a_scan_in_range, clock, reset, (state_ff == ST_READ) || (state_ff == ST_CMP),
      way_ff <= last_way_ff, "way scan ran past the ways in use")

endmodule

`default_nettype wire

FILE: sv/sactl_ram.sv
`default_nettype none

module sactl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
